>>> rtl/alls_pkg.sv
// ----------------------------------------------------------------------------
// alls_pkg
// Shared types, constants and request/response structs of the ambient light
// level scaler.
// ----------------------------------------------------------------------------
package alls_pkg;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned NWEIGHTS  = 4;
  localparam int unsigned NTERMS    = (SLOTS < NWEIGHTS) ? SLOTS : NWEIGHTS;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WIDX_W    = (NWEIGHTS > 1) ? $clog2(NWEIGHTS) : 1;

  localparam int unsigned LIGHT_W   = 10;
  localparam int unsigned WEIGHT_W  = 9;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned REF_W     = LIGHT_W + FRAC_W;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned NUM_W     = LIGHT_W + 11;
  localparam int unsigned ACC_W     = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DIGIT_W   = 2;
  localparam int unsigned NDIGITS   = (WEIGHT_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned DCNT_W    = $clog2(NDIGITS);
  localparam int unsigned PART_W    = LIGHT_W + DIGIT_W;
  localparam int unsigned QCNT_W    = $clog2(LEVEL_W);

  typedef logic [LIGHT_W-1:0]  light_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [REF_W-1:0]    ref_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [NUM_W-1:0]    num_t;
  typedef logic [ACC_W-1:0]    acc_t;

  localparam ref_t    REF_MAX      = {REF_W{1'b1}};
  localparam weight_t WEIGHT_RESET = WEIGHT_W'(64);
  localparam logic    MODE_SAMPLE  = 1'b0;
  localparam logic    MODE_PERIOD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_W_NEWEST        = 2'd0,
    CFG_W_OLDEST        = 2'd1,
    CFG_W_SECOND_OLDEST = 2'd2,
    CFG_W_THIRD_OLDEST  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    num_t num;
    ref_t den;
  } div_req_t;

  typedef struct packed {
    logic   done;
    level_t quo;
  } div_rsp_t;

  typedef struct packed {
    logic  start;
    slot_t ptr;
  } sum_req_t;

  typedef struct packed {
    logic done;
    ref_t sum;
  } sum_rsp_t;

endpackage

>>> rtl/alls_in_if.sv
// ----------------------------------------------------------------------------
// alls_in_if
// Request channel into the scaler: mode and light reading.
// ----------------------------------------------------------------------------
interface alls_in_if;
  import alls_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  light_t light;

  modport source (output valid, output mode, output light, input ready);
  modport sink (input valid, input mode, input light, output ready);

endinterface

>>> rtl/alls_out_if.sv
// ----------------------------------------------------------------------------
// alls_out_if
// Result channel out of the scaler: level, change flag and reference peak.
// ----------------------------------------------------------------------------
interface alls_out_if;
  import alls_pkg::*;

  logic   valid;
  logic   ready;
  level_t level;
  logic   level_changed;
  light_t reference_peak;

  modport source (output valid, output level, output level_changed,
                  output reference_peak, input ready);
  modport sink (input valid, input level, input level_changed,
                input reference_peak, output ready);

endinterface

>>> rtl/ambient_light_level_scaler.sv
// ----------------------------------------------------------------------------
// ambient_light_level_scaler
// Brightness level from ambient light against a reference peak that tracks
// the running peak and a weighted history of period peaks.
// ----------------------------------------------------------------------------
// Light sample: the 3-step quotient loop runs before the result is ready (a
//   zero reference skips it); the next request is taken once the result is loaded.
// Period end: the 4-slot by 5-digit weighted sum runs before the result is
//   ready; the next request is taken once the result is loaded.
// A waiting result sits in the output register while the next request enters.
// Reset clears the peaks, pointer, reference and level; weights go to 64.
module ambient_light_level_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  alls_in_if.sink                    in_if,
  alls_out_if.source                 out_if,
  input  logic                       cfg_we_i,
  input  logic [alls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  alls_pkg::weight_t          cfg_data_i
);
  import alls_pkg::*;

  state_e   state_q, state_d;
  weight_t  weights_q [NWEIGHTS];
  light_t   peaks_q [SLOTS];
  slot_t    ptr_q;
  light_t   run_q;
  ref_t     ref_q;
  level_t   lvl_q;
  logic     chg_q;
  logic     out_valid_q;
  level_t   out_level_q;
  logic     out_chg_q;
  light_t   out_ref_q;

  logic     in_ready;
  logic     in_acc;
  logic     is_period;
  logic     out_free;
  logic     out_load;
  light_t   run_new;
  ref_t     ref_cand;
  ref_t     ref_new;
  slot_t    ptr_new;
  div_req_t div_req;
  div_rsp_t div_rsp;
  sum_req_t sum_req;
  sum_rsp_t sum_rsp;

  assign in_acc    = in_if.valid & in_ready;
  assign is_period = in_if.mode == MODE_PERIOD;
  assign out_free  = !out_valid_q || out_if.ready;

  always_comb begin
    run_new  = (in_if.light > run_q) ? in_if.light : run_q;
    ref_cand = {run_new, {FRAC_W{1'b0}}};
    ref_new  = (ref_cand > ref_q) ? ref_cand : ref_q;
    ptr_new  = (ptr_q == SLOT_W'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_period) begin
            state_d = ST_SUM;
          end else if (ref_new == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_SUM: begin
        if (sum_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
    div_req.start = in_acc && !is_period && (ref_new != '0);
    div_req.num   = {in_if.light, 11'b0} - NUM_W'({in_if.light, {FRAC_W{1'b0}}});
    div_req.den   = ref_new;
    sum_req.start = in_acc && is_period;
    sum_req.ptr   = ptr_new;
  end

  alls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  alls_wsum u_wsum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sum_req),
    .peaks_i   (peaks_q),
    .weights_i (weights_q),
    .rsp_o     (sum_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NWEIGHTS; i++) weights_q[i] <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_W_NEWEST:        weights_q[CFG_W_NEWEST]        <= cfg_data_i;
        CFG_W_OLDEST:        weights_q[CFG_W_OLDEST]        <= cfg_data_i;
        CFG_W_SECOND_OLDEST: weights_q[CFG_W_SECOND_OLDEST] <= cfg_data_i;
        CFG_W_THIRD_OLDEST:  weights_q[CFG_W_THIRD_OLDEST]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < SLOTS; i++) peaks_q[i] <= '0;
      ptr_q       <= '0;
      run_q       <= '0;
      ref_q       <= '0;
      lvl_q       <= '0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (is_period) begin
          ptr_q          <= ptr_new;
          peaks_q[ptr_new] <= run_q;
          run_q          <= in_if.light;
          chg_q          <= 1'b0;
        end else begin
          run_q <= run_new;
          ref_q <= ref_new;
          if (ref_new == '0) begin
            lvl_q <= '0;
            chg_q <= lvl_q != '0;
          end
        end
      end
      if (state_q == ST_DIV && div_rsp.done) begin
        lvl_q <= div_rsp.quo;
        chg_q <= div_rsp.quo != lvl_q;
      end
      if (state_q == ST_SUM && sum_rsp.done) begin
        ref_q <= sum_rsp.sum;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q <= lvl_q;
      out_chg_q   <= chg_q;
      out_ref_q   <= ref_q[REF_W-1:FRAC_W];
    end
  end

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_q;
  assign out_if.level          = out_level_q;
  assign out_if.level_changed  = out_chg_q;
  assign out_if.reference_peak = out_ref_q;

endmodule

>>> rtl/alls_div.sv
// ----------------------------------------------------------------------------
// alls_div
// Restoring divider giving one quotient bit per cycle for the level.
// ----------------------------------------------------------------------------
module alls_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alls_pkg::div_req_t req_i,
  output alls_pkg::div_rsp_t rsp_o
);
  import alls_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  num_t               rem_q, rem_d;
  ref_t               den_q, den_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  level_t             quo_q, quo_d;
  num_t               den_sh;
  logic               fits;

  always_comb begin
    den_sh = NUM_W'(den_q) << cnt_q;
    fits   = rem_q >= den_sh;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = QCNT_W'(LEVEL_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - den_sh;
      end
      quo_d = {quo_q[LEVEL_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> rtl/alls_wsum.sv
// ----------------------------------------------------------------------------
// alls_wsum
// Weighted sum of the stored period peaks, one two-bit weight digit per
// cycle, saturated to the reference range.
// ----------------------------------------------------------------------------
module alls_wsum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alls_pkg::sum_req_t req_i,
  input  alls_pkg::light_t  peaks_i [alls_pkg::SLOTS],
  input  alls_pkg::weight_t weights_i [alls_pkg::NWEIGHTS],
  output alls_pkg::sum_rsp_t rsp_o
);
  import alls_pkg::*;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  slot_t                       ptr_q, ptr_d;
  logic [WIDX_W-1:0]           term_q, term_d;
  logic [DCNT_W-1:0]           dig_q, dig_d;
  acc_t                        acc_q, acc_d;
  ref_t                        sum_q, sum_d;
  logic [SLOT_W:0]             slot_raw;
  slot_t                       slot;
  logic [NDIGITS*DIGIT_W-1:0]  w_ext;
  logic [DIGIT_W-1:0]          digit;
  logic [PART_W-1:0]           part;
  acc_t                        addend;
  acc_t                        acc_new;
  logic                        last_dig;
  logic                        last_term;

  always_comb begin
    slot_raw = (SLOT_W+1)'(ptr_q) + (SLOT_W+1)'(term_q);
    if (slot_raw >= (SLOT_W+1)'(SLOTS)) begin
      slot_raw = slot_raw - (SLOT_W+1)'(SLOTS);
    end
    slot      = slot_raw[SLOT_W-1:0];
    w_ext     = (NDIGITS*DIGIT_W)'(weights_i[term_q]);
    digit     = w_ext[dig_q*DIGIT_W +: DIGIT_W];
    part      = PART_W'(peaks_i[slot]) * PART_W'(digit);
    addend    = ACC_W'(part) << (dig_q * DIGIT_W);
    acc_new   = acc_q + addend;
    last_dig  = dig_q == DCNT_W'(NDIGITS - 1);
    last_term = term_q == WIDX_W'(NTERMS - 1);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ptr_d  = ptr_q;
    term_d = term_q;
    dig_d  = dig_q;
    acc_d  = acc_q;
    sum_d  = sum_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      ptr_d  = req_i.ptr;
      term_d = '0;
      dig_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_new;
      if (last_dig) begin
        dig_d  = '0;
        term_d = term_q + 1'b1;
        if (last_term) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          sum_d  = (acc_new > ACC_W'(REF_MAX)) ? REF_MAX : acc_new[REF_W-1:0];
        end
      end else begin
        dig_d = dig_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      term_q <= '0;
      dig_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      term_q <= term_d;
      dig_q  <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    acc_q <= acc_d;
    sum_q <= sum_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sum  = sum_q;

endmodule

>>> rtl/alls_checker.sv
// ----------------------------------------------------------------------------
// alls_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module alls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input alls_pkg::level_t  out_level_i,
  input logic              out_changed_i,
  input alls_pkg::light_t  out_ref_i
);
  import alls_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_level_i) && $stable(out_changed_i) && $stable(out_ref_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in progress");

  a_level_needs_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_changed_i && out_level_i != '0 |-> out_ref_i != '0)
    else $error("nonzero level with zero reference peak");

endmodule

bind ambient_light_level_scaler alls_checker u_alls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_level_i   (out_if.level),
  .out_changed_i (out_if.level_changed),
  .out_ref_i     (out_if.reference_peak)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ambient light level scaler. A scoreboard keeps
// its own copy of the peaks, ring pointer, reference and weights, predicts
// one result for every accepted request and compares it field by field.
// Directed corners come first, then random traffic in several weight phases
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import alls_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned LEVEL_TOP     = 7;

  typedef struct packed {
    level_t level;
    logic   changed;
    light_t reference;
  } scaled_level_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  cfg_idx_e        cfg_idx_i;
  weight_t         cfg_data_i;

  alls_in_if  in_if ();
  alls_out_if out_if ();

  ambient_light_level_scaler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  weight_t         slot_weights [NWEIGHTS];
  light_t          period_peaks [SLOTS];
  slot_t           ring_ptr;
  light_t          running_peak;
  ref_t            reference_q8;
  level_t          held_level;

  scaled_level_t   pending_levels [$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     stall_left = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic void scale_light(logic mode, light_t light);
    scaled_level_t res;
    int unsigned   quotient;
    int unsigned   sum;
    level_t        lvl;
    res.changed = 1'b0;
    if (mode == MODE_SAMPLE) begin
      if (light > running_peak) running_peak = light;
      if ({running_peak, {FRAC_W{1'b0}}} > reference_q8) begin
        reference_q8 = {running_peak, {FRAC_W{1'b0}}};
      end
      lvl = '0;
      if (reference_q8 != '0) begin
        quotient = (int'(light) * LEVEL_TOP * (1 << FRAC_W)) / int'(reference_q8);
        lvl = (quotient > LEVEL_TOP) ? level_t'(LEVEL_TOP) : level_t'(quotient);
      end
      if (lvl != held_level) begin
        held_level  = lvl;
        res.changed = 1'b1;
      end
    end else begin
      ring_ptr = slot_t'((int'(ring_ptr) + 1) % SLOTS);
      period_peaks[ring_ptr] = running_peak;
      sum = 0;
      for (int unsigned i = 0; i < NTERMS; i++) begin
        sum += int'(period_peaks[(int'(ring_ptr) + i) % SLOTS]) * int'(slot_weights[i]);
      end
      reference_q8 = (sum > int'(REF_MAX)) ? REF_MAX : ref_t'(sum);
      running_peak = light;
    end
    res.level     = held_level;
    res.reference = reference_q8[REF_W-1:FRAC_W];
    pending_levels.push_back(res);
  endfunction

  function automatic void check_result();
    scaled_level_t exp_res;
    if (pending_levels.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: result with none expected: level %0d changed %0b reference %0d",
                 $realtime, out_if.level, out_if.level_changed, out_if.reference_peak);
      end
      return;
    end
    exp_res = pending_levels.pop_front();
    if (out_if.level !== exp_res.level || out_if.level_changed !== exp_res.changed ||
        out_if.reference_peak !== exp_res.reference) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: mismatch level %0d/%0d changed %0b/%0b reference %0d/%0d (exp/got)",
                 $realtime, exp_res.level, out_if.level, exp_res.changed,
                 out_if.level_changed, exp_res.reference, out_if.reference_peak);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_result();
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap(stall_pct);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[ambient_light_level_scaler] ERROR");
    $finish;
  end

  task automatic send_request(logic mode, light_t light);
    int unsigned gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.light <= light;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scale_light(mode, light);
  endtask

  task automatic settle_scaler();
    in_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_weight(cfg_idx_e idx, weight_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    slot_weights[idx] = value;
  endtask

  task automatic set_weights(weight_t w_newest, weight_t w_oldest,
                             weight_t w_second, weight_t w_third);
    settle_scaler();
    write_weight(CFG_W_NEWEST, w_newest);
    write_weight(CFG_W_OLDEST, w_oldest);
    write_weight(CFG_W_SECOND_OLDEST, w_second);
    write_weight(CFG_W_THIRD_OLDEST, w_third);
    cfg_we_i <= 1'b0;
  endtask

  function automatic weight_t random_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return weight_t'(256);
      2:       return weight_t'($urandom_range(257, 511));
      default: return weight_t'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic light_t random_light();
    case ($urandom_range(5))
      0:       return '0;
      1:       return {LIGHT_W{1'b1}};
      2:       return light_t'($urandom_range(0, 63));
      3:       return light_t'($urandom_range(running_peak / 2, running_peak));
      default: return light_t'($urandom());
    endcase
  endfunction

  task automatic test_reset_weights();
    send_idle_pct = 30;
    stall_pct     = 30;
    send_request(MODE_SAMPLE, '0);
    send_request(MODE_SAMPLE, {LIGHT_W{1'b1}});
    send_request(MODE_SAMPLE, '0);
    send_request(MODE_PERIOD, '0);
    send_request(MODE_SAMPLE, light_t'(255));
    send_request(MODE_SAMPLE, light_t'(255));
    send_request(MODE_PERIOD, {LIGHT_W{1'b1}});
    send_request(MODE_SAMPLE, light_t'(512));
  endtask

  task automatic test_weight_extremes();
    set_weights({WEIGHT_W{1'b1}}, {WEIGHT_W{1'b1}}, {WEIGHT_W{1'b1}}, {WEIGHT_W{1'b1}});
    send_request(MODE_SAMPLE, {LIGHT_W{1'b1}});
    send_request(MODE_PERIOD, {LIGHT_W{1'b1}});
    send_request(MODE_PERIOD, {LIGHT_W{1'b1}});
    send_request(MODE_SAMPLE, light_t'(1));
    set_weights('0, '0, '0, '0);
    send_request(MODE_PERIOD, '0);
    send_request(MODE_SAMPLE, '0);
    send_request(MODE_SAMPLE, light_t'(5));
    set_weights(weight_t'(256), '0, '0, weight_t'(256));
    send_request(MODE_PERIOD, light_t'(700));
    send_request(MODE_SAMPLE, light_t'(350));
    send_request(MODE_PERIOD, '0);
    send_request(MODE_SAMPLE, light_t'(1000));
  endtask

  task automatic test_random_traffic();
    logic mode;
    int unsigned burst;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        set_weights(WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
      end else begin
        set_weights(random_weight(), random_weight(), random_weight(), random_weight());
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 20; stall_pct = 20; end
        2: begin send_idle_pct = 60; stall_pct = 10; end
        default: begin send_idle_pct = 10; stall_pct = 60; end
      endcase
      burst = 0;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase % 2 == 1 && n == PHASE_ITEMS / 2) settle_scaler();
        if (burst == 0 && $urandom_range(29) == 0) burst = $urandom_range(2, 6);
        if (burst > 0) begin
          burst--;
          mode = MODE_PERIOD;
        end else begin
          mode = ($urandom_range(7) == 0) ? MODE_PERIOD : MODE_SAMPLE;
        end
        send_request(mode, random_light());
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_W_NEWEST;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_SAMPLE;
    in_if.light   <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int unsigned i = 0; i < NWEIGHTS; i++) slot_weights[i] = WEIGHT_RESET;
    for (int unsigned i = 0; i < SLOTS; i++) period_peaks[i] = '0;
    ring_ptr     = '0;
    running_peak = '0;
    reference_q8 = '0;
    held_level   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_weights();
    test_weight_extremes();
    test_random_traffic();

    settle_scaler();
    if (error_count == 0) begin
      $display("[ambient_light_level_scaler] OK");
    end else begin
      $display("[ambient_light_level_scaler] ERROR");
    end
    $finish;
  end

endmodule
